@@ design/psg_pkg.sv @@
`timescale 1ns / 1ps

package psg_pkg;

  // field widths
  localparam int VOL_W      = 9;
  localparam int POS_W      = 24;
  localparam int DIFF_W     = POS_W + 1;
  localparam int YAW_W      = 16;
  localparam int RAD_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // rotation and distance
  localparam int PROD_W     = DIFF_W + YAW_W;      // one rotation product
  localparam int SUM_W      = PROD_W + 1;          // rotated component, Q14
  localparam int FRAC       = 14;
  localparam int XA_W       = 27;                  // integer magnitude after rotation
  localparam int SQ_W       = 2 * XA_W;            // radicand
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIST_W     = XA_W + 2;
  localparam int DEN_W      = XA_W + 1;
  localparam int REM_W      = 27;
  localparam int DIV_STEPS  = 16;

  // pan angle
  localparam int CORD_W     = 50;
  localparam int ANG_W      = 19;
  localparam int PRE        = 20;

  // attenuation and gain
  localparam int K_W         = 17;
  localparam int Q16_ONE     = 65536;
  localparam int ATT_OFFSET  = 1224;
  localparam int DIV_NUM     = ATT_OFFSET * Q16_ONE;
  localparam int ATT_NEAR    = 6000;
  localparam int ATT_FAR     = 10000;
  localparam int ATT_SPAN    = 4000;
  localparam int ATT_W       = 12;
  localparam longint ATT_RECIP = (64'd1 << 40) / ATT_SPAN;
  localparam int RECIP_SHIFT = 40;
  localparam int VOL_FLAT    = 180;
  localparam int VOL_POS     = 200;
  localparam int PAN_BASE    = 45875;
  localparam int PAN_NEAR    = 19661;
  localparam int PAN_FAR     = 39322;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X  = 3'd0,
    CFG_CAMERA_Y  = 3'd1,
    CFG_CAMERA_Z  = 3'd2,
    CFG_YAW_COS   = 3'd3,
    CFG_YAW_SIN   = 3'd4,
    CFG_MIN_RAD   = 3'd5
  } cfg_index_t;

  // one item as it travels down the cell row
  typedef struct packed {
    logic [VOL_W-1:0]         vol;
    logic                     flat;
    logic                     near_right;
    logic                     xa_zero;
    logic                     za_zero;
    logic [SQ_W-1:0]          rad_n;
    logic [SQ_W-1:0]          rad_r;
    logic signed [CORD_W-1:0] cx;
    logic signed [CORD_W-1:0] cy;
    logic signed [ANG_W-1:0]  ang;
    logic signed [DIST_W-1:0] rdist;
    logic                     dpos;
    logic [DEN_W-1:0]         den;
    logic [REM_W-1:0]         rem;
    logic [DIV_STEPS-1:0]     quo;
  } psg_data_t;

  // atan(2^-i) scaled so that pi/2 is 65536, rounded
  function automatic logic [ANG_W-1:0] atan_step(input int i);
    logic [ANG_W-1:0] v;
    case (i)
      0:  v = 19'd32768;
      1:  v = 19'd19344;
      2:  v = 19'd10221;
      3:  v = 19'd5188;
      4:  v = 19'd2604;
      5:  v = 19'd1303;
      6:  v = 19'd652;
      7:  v = 19'd326;
      8:  v = 19'd163;
      9:  v = 19'd81;
      10: v = 19'd41;
      11: v = 19'd20;
      12: v = 19'd10;
      13: v = 19'd5;
      14: v = 19'd3;
      15: v = 19'd1;
      16: v = 19'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] sat16(input logic [18:0] g);
    return (g > 19'd65535) ? {GAIN_W{1'b1}} : g[GAIN_W-1:0];
  endfunction

endpackage

@@ design/psg_in_if.sv @@
`timescale 1ns / 1ps

interface psg_in_if import psg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [VOL_W-1:0]        base_volume;
  logic signed [POS_W-1:0] source_x;
  logic signed [POS_W-1:0] source_y;
  logic signed [POS_W-1:0] source_z;

  modport source (output valid, base_volume, source_x, source_y, source_z, input ready);
  modport sink   (input valid, base_volume, source_x, source_y, source_z, output ready);
endinterface

@@ design/psg_out_if.sv @@
`timescale 1ns / 1ps

interface psg_out_if import psg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] left_gain;
  logic [GAIN_W-1:0] right_gain;

  modport source (output valid, left_gain, right_gain, input ready);
  modport sink   (input valid, left_gain, right_gain, output ready);
endinterface

@@ design/positional_stereo_gain_unit.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// in_ch     in   valid / ready      base_volume, source_x, source_y, source_z
// out_ch    out  valid / ready      left_gain, right_gain
// cfg_*     in   cfg_we (no ready)  cfg_index, cfg_data
//
// One item per cycle while out_ch is not stalling; 5 front stages, 27 square-root
// cells (the first ANGLE_ITERATIONS of them also carry the pan rotation), 1 setup cell,
// 16 divider cells, 6 gain stages ending in the output register.
// rst_n is synchronous; it clears valid bits and loads register defaults.
// The whole row advances together; it stops only while a result sits in the
// output register and out_ch.ready is low, so in_ch.ready follows that.

module positional_stereo_gain_unit import psg_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  psg_in_if.sink                in_ch,
  psg_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NCELL = SQRT_STEPS + 1 + DIV_STEPS;

  // listener registers
  logic signed [POS_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [YAW_W-1:0] yaw_cos_r, yaw_sin_r;
  logic [RAD_W-1:0]        min_rad_r;

  // row advance
  logic en;
  logic out_valid;

  logic      chain_valid [NCELL+1];
  psg_data_t chain_data  [NCELL+1];

  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = out_valid;

  // config writes; unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_z_r   <= '0;
      yaw_cos_r <= YAW_W'(16384);
      yaw_sin_r <= '0;
      min_rad_r <= RAD_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CAMERA_X: cam_x_r   <= cfg_data;
        CFG_CAMERA_Y: cam_y_r   <= cfg_data;
        CFG_CAMERA_Z: cam_z_r   <= cfg_data;
        CFG_YAW_COS:  yaw_cos_r <= cfg_data[YAW_W-1:0];
        CFG_YAW_SIN:  yaw_sin_r <= cfg_data[YAW_W-1:0];
        CFG_MIN_RAD:  min_rad_r <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // offset, rotation, magnitudes and squares
  psg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_ch.valid),
    .base_volume (in_ch.base_volume),
    .source_x    (in_ch.source_x),
    .source_y    (in_ch.source_y),
    .source_z    (in_ch.source_z),
    .camera_x    (cam_x_r),
    .camera_y    (cam_y_r),
    .camera_z    (cam_z_r),
    .yaw_cosine  (yaw_cos_r),
    .yaw_sine    (yaw_sin_r),
    .out_valid_r (chain_valid[0]),
    .out_data_r  (chain_data[0])
  );

  // cell row: sqrt bit + pan rotation, then divider setup, then quotient bits
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    psg_cell #(
      .IDX              (i),
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .rad_floor   (min_rad_r),
      .in_valid    (chain_valid[i]),
      .in_data     (chain_data[i]),
      .out_valid_r (chain_valid[i+1]),
      .out_data_r  (chain_data[i+1])
    );
  end

  // attenuation, pan gains, final products and output register
  psg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (chain_valid[NCELL]),
    .in_data     (chain_data[NCELL]),
    .out_valid_r (out_valid),
    .left_r      (out_ch.left_gain),
    .right_r     (out_ch.right_gain)
  );

endmodule

@@ design/psg_front.sv @@
`timescale 1ns / 1ps

module psg_front import psg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [VOL_W-1:0]        base_volume,
  input  logic signed [POS_W-1:0] source_x,
  input  logic signed [POS_W-1:0] source_y,
  input  logic signed [POS_W-1:0] source_z,
  input  logic signed [POS_W-1:0] camera_x,
  input  logic signed [POS_W-1:0] camera_y,
  input  logic signed [POS_W-1:0] camera_z,
  input  logic signed [YAW_W-1:0] yaw_cosine,
  input  logic signed [YAW_W-1:0] yaw_sine,
  output logic                    out_valid_r,
  output psg_data_t               out_data_r
);

  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: offset from listener
  logic                     flat1_r;
  logic [VOL_W-1:0]         vol1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, dz1_r;

  // stage 2: rotation products
  logic                     flat2_r;
  logic [VOL_W-1:0]         vol2_r;
  logic signed [PROD_W-1:0] xc2_r, zs2_r, zc2_r, xs2_r;
  logic [DIFF_W-1:0]        ay2_r;
  logic [DIFF_W-1:0]        ay_c;

  // stage 3: integer magnitudes
  logic                     flat3_r, right3_r;
  logic [VOL_W-1:0]         vol3_r;
  logic [XA_W-1:0]          xa3_r, za3_r;
  logic [DIFF_W-1:0]        ay3_r;
  logic signed [SUM_W-1:0]  xq_c, zq_c;
  logic [SUM_W-1:0]         xm_c, zm_c;

  // stage 4: squares
  logic                     flat4_r, right4_r;
  logic [VOL_W-1:0]         vol4_r;
  logic [XA_W-1:0]          xa4_r, za4_r;
  logic [SQ_W-1:0]          sqx4_r, sqz4_r, sqy4_r;

  psg_data_t data_nxt;

  assign ay_c = dy1_r[DIFF_W-1] ? DIFF_W'(-dy1_r) : DIFF_W'(dy1_r);
  assign xq_c = SUM_W'(xc2_r) + SUM_W'(zs2_r);
  assign zq_c = SUM_W'(zc2_r) - SUM_W'(xs2_r);
  assign xm_c = xq_c[SUM_W-1] ? SUM_W'(-xq_c) : SUM_W'(xq_c);
  assign zm_c = zq_c[SUM_W-1] ? SUM_W'(-zq_c) : SUM_W'(zq_c);

  always_comb begin
    data_nxt            = '0;
    data_nxt.vol        = vol4_r;
    data_nxt.flat       = flat4_r;
    data_nxt.near_right = right4_r;
    data_nxt.xa_zero    = (xa4_r == '0);
    data_nxt.za_zero    = (za4_r == '0);
    data_nxt.rad_n      = sqx4_r + sqz4_r + sqy4_r;
    data_nxt.cy         = $signed(CORD_W'(xa4_r) << PRE);
    data_nxt.cx         = $signed(CORD_W'(za4_r) << PRE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flat1_r    <= (source_x == '0);
      vol1_r     <= base_volume;
      dx1_r      <= DIFF_W'(source_x) - DIFF_W'(camera_x);
      dy1_r      <= DIFF_W'(source_y) - DIFF_W'(camera_y);
      dz1_r      <= DIFF_W'(source_z) - DIFF_W'(camera_z);

      flat2_r    <= flat1_r;
      vol2_r     <= vol1_r;
      xc2_r      <= PROD_W'(dx1_r) * PROD_W'(yaw_cosine);
      zs2_r      <= PROD_W'(dz1_r) * PROD_W'(yaw_sine);
      zc2_r      <= PROD_W'(dz1_r) * PROD_W'(yaw_cosine);
      xs2_r      <= PROD_W'(dx1_r) * PROD_W'(yaw_sine);
      ay2_r      <= ay_c;

      flat3_r    <= flat2_r;
      vol3_r     <= vol2_r;
      right3_r   <= !xq_c[SUM_W-1] && (xq_c != '0);
      xa3_r      <= xm_c[XA_W+FRAC-1:FRAC];
      za3_r      <= zm_c[XA_W+FRAC-1:FRAC];
      ay3_r      <= ay2_r;

      flat4_r    <= flat3_r;
      vol4_r     <= vol3_r;
      right4_r   <= right3_r;
      xa4_r      <= xa3_r;
      za4_r      <= za3_r;
      sqx4_r     <= SQ_W'(xa3_r) * SQ_W'(xa3_r);
      sqz4_r     <= SQ_W'(za3_r) * SQ_W'(za3_r);
      sqy4_r     <= SQ_W'(ay3_r) * SQ_W'(ay3_r);

      out_data_r <= data_nxt;
    end
  end

endmodule

@@ design/psg_cell.sv @@
`timescale 1ns / 1ps

module psg_cell import psg_pkg::*; #(
  parameter int IDX              = 0,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [RAD_W-1:0] rad_floor,
  input  logic             in_valid,
  input  psg_data_t        in_data,
  output logic             out_valid_r,
  output psg_data_t        out_data_r
);

  localparam int SQ_SH = (IDX < SQRT_STEPS) ? (SQ_W - 2 - 2 * IDX) : 0;
  localparam int CO_SH = (IDX < ANGLE_ITERATIONS) ? IDX : 0;
  localparam int DV_SH = (IDX > SQRT_STEPS) ? (DIV_STEPS + SQRT_STEPS - IDX) : 0;
  localparam int DSH_W = DEN_W + DIV_STEPS;
  localparam logic [ANG_W-1:0] ATAN_C = atan_step(IDX);

  logic [SQ_W-1:0]          sq_bit, sq_trial;
  logic [DSH_W-1:0]         dv_shift;
  logic signed [DIST_W-1:0] dist_c;
  psg_data_t                data_nxt;

  assign sq_bit   = SQ_W'(1) << SQ_SH;
  assign sq_trial = in_data.rad_r + sq_bit;
  assign dv_shift = DSH_W'(in_data.den) << DV_SH;
  assign dist_c   = $signed(DIST_W'(in_data.rad_r[XA_W-1:0])) - $signed(DIST_W'(rad_floor));

  always_comb begin
    data_nxt = in_data;

    // one result bit of the square root
    if (IDX < SQRT_STEPS) begin
      if (in_data.rad_n >= sq_trial) begin
        data_nxt.rad_n = in_data.rad_n - sq_trial;
        data_nxt.rad_r = (in_data.rad_r >> 1) + sq_bit;
      end else begin
        data_nxt.rad_r = in_data.rad_r >> 1;
      end
    end

    // one vectoring rotation; a zero y stays put
    if ((IDX < ANGLE_ITERATIONS) && (in_data.cy != '0)) begin
      if (!in_data.cy[CORD_W-1]) begin
        data_nxt.cx  = in_data.cx + (in_data.cy >>> CO_SH);
        data_nxt.cy  = in_data.cy - (in_data.cx >>> CO_SH);
        data_nxt.ang = in_data.ang + $signed(ATAN_C);
      end else begin
        data_nxt.cx  = in_data.cx - (in_data.cy >>> CO_SH);
        data_nxt.cy  = in_data.cy + (in_data.cx >>> CO_SH);
        data_nxt.ang = in_data.ang - $signed(ATAN_C);
      end
    end

    // distance past min radius and divider setup
    if (IDX == SQRT_STEPS) begin
      data_nxt.rdist = dist_c;
      data_nxt.dpos  = !dist_c[DIST_W-1] && (dist_c != '0);
      data_nxt.den   = (!dist_c[DIST_W-1] && (dist_c != '0)) ?
                       DEN_W'(dist_c) + DEN_W'(ATT_OFFSET) : DEN_W'(ATT_OFFSET);
      data_nxt.rem   = REM_W'(DIV_NUM);
      data_nxt.quo   = '0;
    end

    // one quotient bit, restoring
    if ((IDX > SQRT_STEPS) && (DSH_W'(in_data.rem) >= dv_shift)) begin
      data_nxt.rem        = in_data.rem - REM_W'(dv_shift);
      data_nxt.quo[DV_SH] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_nxt;
    end
  end

endmodule

@@ design/psg_back.sv @@
`timescale 1ns / 1ps

module psg_back import psg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  psg_data_t         in_data,
  output logic              out_valid_r,
  output logic [GAIN_W-1:0] left_r,
  output logic [GAIN_W-1:0] right_r
);

  localparam int PRD_W = K_W + ATT_W;
  localparam int RM_W  = 2 * PRD_W;
  localparam int Q0_W  = 18;
  localparam int M1_W  = 2 * K_W;
  localparam int G_W   = M1_W + K_W;
  localparam int FV_W  = 17;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1
  logic [K_W-1:0]    k_c, p_c;
  logic [DIST_W-1:0] t_c;
  logic [K_W-1:0]    k1_r, p1_r;
  logic [ATT_W-1:0]  t1_r;
  logic              far1_r, gone1_r, flat1_r, right1_r;
  logic [VOL_W-1:0]  vol1_r;

  // stage 2
  logic [31:0]       pn_c, pf_c;
  logic [PRD_W-1:0]  prod2_r;
  logic [K_W-1:0]    k2_r, near2_r, v2g_r;
  logic [GAIN_W-1:0] farg2_r;
  logic              far2_r, gone2_r, flat2_r, right2_r;
  logic [VOL_W-1:0]  vol2_r;

  // stage 3
  logic [RM_W-1:0]   qm_c;
  logic [PRD_W-1:0]  prod3_r;
  logic [Q0_W-1:0]   q03_r;
  logic [K_W-1:0]    k3_r;
  logic [M1_W-1:0]   m1n3_r, m1f3_r;
  logic              far3_r, gone3_r, flat3_r, right3_r;
  logic [VOL_W-1:0]  vol3_r;

  // stage 4
  logic [PRD_W-1:0]  rem_c;
  logic [K_W-1:0]    kf_c;
  logic [K_W-1:0]    k4_r;
  logic [M1_W-1:0]   m1n4_r, m1f4_r;
  logic              flat4_r, right4_r;
  logic [VOL_W-1:0]  vol4_r;

  // stage 5
  logic [G_W-1:0]    gn5_r, gf5_r;
  logic              flat5_r, right5_r;
  logic [VOL_W-1:0]  vol5_r;

  // output
  logic [FV_W-1:0]   fv_c;
  logic [GAIN_W-1:0] gn_c, gf_c, fl_c;
  logic              flat6_r, right6_r;

  assign k_c = in_data.dpos ? K_W'(in_data.quo) : K_W'(Q16_ONE);
  assign t_c = DIST_W'(ATT_FAR) - in_data.rdist;

  always_comb begin
    if (in_data.xa_zero) begin
      p_c = '0;
    end else if (in_data.za_zero) begin
      p_c = K_W'(Q16_ONE);
    end else if (in_data.ang[ANG_W-1]) begin
      p_c = '0;
    end else if (in_data.ang > ANG_W'(Q16_ONE)) begin
      p_c = K_W'(Q16_ONE);
    end else begin
      p_c = in_data.ang[K_W-1:0];
    end
  end

  assign pn_c = 32'(p1_r) * 32'(PAN_NEAR);
  assign pf_c = 32'(p1_r) * 32'(PAN_FAR);
  assign qm_c = RM_W'(prod2_r) * RM_W'(ATT_RECIP);

  assign rem_c = prod3_r - PRD_W'(PRD_W'(q03_r) * PRD_W'(ATT_SPAN));

  always_comb begin
    if (gone3_r) begin
      kf_c = '0;
    end else if (far3_r) begin
      kf_c = (rem_c >= PRD_W'(ATT_SPAN)) ? K_W'(q03_r + 1'b1) : K_W'(q03_r);
    end else begin
      kf_c = k3_r;
    end
  end

  assign fv_c = FV_W'(vol5_r) * FV_W'(VOL_FLAT);
  assign gn_c = sat16(gn5_r[G_W-1:32]);
  assign gf_c = sat16(gf5_r[G_W-1:32]);
  assign fl_c = sat16(19'(fv_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_r     <= k_c;
      p1_r     <= p_c;
      t1_r     <= t_c[ATT_W-1:0];
      far1_r   <= in_data.rdist > DIST_W'(ATT_NEAR);
      gone1_r  <= in_data.rdist >= DIST_W'(ATT_FAR);
      flat1_r  <= in_data.flat;
      right1_r <= in_data.near_right;
      vol1_r   <= in_data.vol;

      prod2_r  <= PRD_W'(k1_r) * PRD_W'(t1_r);
      k2_r     <= k1_r;
      near2_r  <= K_W'(PAN_BASE) + K_W'(pn_c[31:16]);
      farg2_r  <= GAIN_W'(PAN_BASE) - pf_c[31:16];
      v2g_r    <= K_W'(vol1_r) * K_W'(VOL_POS);
      far2_r   <= far1_r;
      gone2_r  <= gone1_r;
      flat2_r  <= flat1_r;
      right2_r <= right1_r;
      vol2_r   <= vol1_r;

      prod3_r  <= prod2_r;
      q03_r    <= qm_c[RECIP_SHIFT+Q0_W-1:RECIP_SHIFT];
      k3_r     <= k2_r;
      m1n3_r   <= M1_W'(v2g_r) * M1_W'(near2_r);
      m1f3_r   <= M1_W'(v2g_r) * M1_W'(farg2_r);
      far3_r   <= far2_r;
      gone3_r  <= gone2_r;
      flat3_r  <= flat2_r;
      right3_r <= right2_r;
      vol3_r   <= vol2_r;

      k4_r     <= kf_c;
      m1n4_r   <= m1n3_r;
      m1f4_r   <= m1f3_r;
      flat4_r  <= flat3_r;
      right4_r <= right3_r;
      vol4_r   <= vol3_r;

      gn5_r    <= G_W'(m1n4_r) * G_W'(k4_r);
      gf5_r    <= G_W'(m1f4_r) * G_W'(k4_r);
      flat5_r  <= flat4_r;
      right5_r <= right4_r;
      vol5_r   <= vol4_r;

      flat6_r  <= flat5_r;
      right6_r <= right5_r;
      if (flat5_r) begin
        left_r  <= fl_c;
        right_r <= fl_c;
      end else if (right5_r) begin
        left_r  <= gf_c;
        right_r <= gn_c;
      end else begin
        left_r  <= gn_c;
        right_r <= gf_c;
      end
    end
  end

  // reciprocal estimate is off by at most one
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && far3_r) |-> (rem_c < PRD_W'(2 * ATT_SPAN)))
    else $error("attenuation quotient correction out of range");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (k4_r <= K_W'(Q16_ONE)))
    else $error("distance factor above unity");

  // far ear never louder than near ear
  a_pan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !flat6_r) |-> (right6_r ? (left_r <= right_r) : (right_r <= left_r)))
    else $error("far-side gain exceeds near-side gain");

endmodule

@@ tb/sv/positional_stereo_gain_unit_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the stereo gain unit: directed corners, then
// random voices under several listener settings, random stalls on both sides.
module positional_stereo_gain_unit_tb;
  import psg_pkg::*;

  typedef struct packed {
    logic [GAIN_W-1:0] left;
    logic [GAIN_W-1:0] right;
  } gain_pair_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  psg_in_if  in_ch ();
  psg_out_if out_ch ();

  positional_stereo_gain_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int LATENCY = 55;
  localparam longint CYCLE_LIMIT = 400000;

  // listener registers as the predictor sees them
  longint cam_x, cam_y, cam_z, yaw_c, yaw_s, min_rad;

  gain_pair_t expected_gains[$];
  int mismatches;
  int gain_pairs_seen;
  int voices_sent;
  longint cycles;
  bit quiet_phase;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;  // arithmetic shift floors for signed longint
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // pan angle, atan2(lat, fwd) scaled so pi/2 = 65536
  function automatic longint pan_q16(longint lat, longint fwd);
    longint x, y, a, nx, ny, step;
    if (lat == 0) return 0;
    if (fwd == 0) return 65536;
    x = fwd <<< 20;
    y = lat <<< 20;
    a = 0;
    for (int i = 0; i < 16; i++) begin
      if (y == 0) break;
      case (i)
        0: step = 32768;  1: step = 19344; 2: step = 10221; 3: step = 5188;
        4: step = 2604;   5: step = 1303;  6: step = 652;   7: step = 326;
        8: step = 163;    9: step = 81;    10: step = 41;   11: step = 20;
        12: step = 10;    13: step = 5;    14: step = 3;    default: step = 1;
      endcase
      if (y > 0) begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        a += step;
      end else begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        a -= step;
      end
      x = nx;
      y = ny;
    end
    if (a < 0) a = 0;
    if (a > 65536) a = 65536;
    return a;
  endfunction

  function automatic logic [GAIN_W-1:0] clip_gain(longint g);
    return (g > 65535) ? 16'hFFFF : g[GAIN_W-1:0];
  endfunction

  function automatic gain_pair_t predict_gains(logic [VOL_W-1:0] vol,
      logic signed [POS_W-1:0] sx, logic signed [POS_W-1:0] sy,
      logic signed [POS_W-1:0] sz);
    gain_pair_t g;
    longint dx, dy, dz, xq, zq, xa, za, ya, d, k, p, near_q, far_q, v;
    logic [127:0] prod;
    logic [GAIN_W-1:0] gn, gf;
    if (sx == 0) begin
      g.left = clip_gain(longint'(vol) * VOL_FLAT);
      g.right = g.left;
      return g;
    end
    v = longint'(vol) * VOL_POS;
    dx = longint'(sx) - cam_x;
    dy = longint'(sy) - cam_y;
    dz = longint'(sz) - cam_z;
    xq = dx * yaw_c + dz * yaw_s;
    zq = dz * yaw_c - dx * yaw_s;
    xa = (xq < 0 ? -xq : xq) >>> 14;
    za = (zq < 0 ? -zq : zq) >>> 14;
    ya = dy < 0 ? -dy : dy;
    d = int_sqrt(xa * xa + ya * ya + za * za) - min_rad;
    if (d <= 0) k = 65536;
    else k = (longint'(1224) <<< 16) / (1224 + d);
    if (d > ATT_NEAR) begin
      if (d >= ATT_FAR) k = 0;
      else k = (k * (ATT_FAR - d)) / ATT_SPAN;
    end
    p = pan_q16(xa, za);
    near_q = PAN_BASE + ((PAN_NEAR * p) >>> 16);
    far_q = PAN_BASE - ((PAN_FAR * p) >>> 16);
    prod = 128'(v) * 128'(near_q) * 128'(k);
    gn = clip_gain(longint'(prod >> 32));
    prod = 128'(v) * 128'(far_q) * 128'(k);
    gf = clip_gain(longint'(prod >> 32));
    if (xq > 0) begin
      g.left = gf;
      g.right = gn;
    end else begin
      g.left = gn;
      g.right = gf;
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d (pair %0d)", what, got, want,
             gain_pairs_seen);
  endtask

  // random idle: about 7 in 100, none during the quiet phase
  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 7);
  endfunction

  // result side: ready toggles on the falling edge, transfer checked on rising
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !idle_now();
  end

  always @(posedge clk) begin
    gain_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_gains.size() == 0) begin
        report_mismatch("unexpected pair, left", out_ch.left_gain, -1);
      end else begin
        want = expected_gains.pop_front();
        if (out_ch.left_gain !== want.left)
          report_mismatch("left_gain", out_ch.left_gain, want.left);
        if (out_ch.right_gain !== want.right)
          report_mismatch("right_gain", out_ch.right_gain, want.right);
      end
      gain_pairs_seen++;
    end
  end

  // one voice; the expectation is queued at the accepting edge.
  // valid stays up into the next call so voices can go back to back.
  task automatic send_voice(input logic [VOL_W-1:0] vol,
      input logic signed [POS_W-1:0] sx, input logic signed [POS_W-1:0] sy,
      input logic signed [POS_W-1:0] sz);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.base_volume <= vol;
    in_ch.source_x <= sx;
    in_ch.source_y <= sy;
    in_ch.source_z <= sz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_gains.push_back(predict_gains(vol, sx, sy, sz));
    voices_sent++;
    @(negedge clk);
  endtask

  // register writes only with the pipe drained
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (expected_gains.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    case (idx)
      CFG_CAMERA_X: cam_x = longint'($signed(value[23:0]));
      CFG_CAMERA_Y: cam_y = longint'($signed(value[23:0]));
      CFG_CAMERA_Z: cam_z = longint'($signed(value[23:0]));
      CFG_YAW_COS:  yaw_c = longint'($signed(value[15:0]));
      CFG_YAW_SIN:  yaw_s = longint'($signed(value[15:0]));
      default:      min_rad = longint'(value[15:0]);
    endcase
  endtask

  task automatic set_listener(input longint x, input longint y, input longint z,
      input longint c, input longint s, input longint r);
    drain_pipe();
    write_reg(CFG_CAMERA_X, x);
    write_reg(CFG_CAMERA_Y, y);
    write_reg(CFG_CAMERA_Z, z);
    write_reg(CFG_YAW_COS, c);
    write_reg(CFG_YAW_SIN, s);
    write_reg(CFG_MIN_RAD, r);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(3))
      0: return POS_W'($urandom);                          // anywhere
      1: return $signed(24'($urandom_range(20000))) - 24'sd10000;  // near
      2: return $signed(24'($urandom_range(400))) - 24'sd200;
      default: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] rand_vol();
    return ($urandom_range(9) == 0) ? VOL_W'($urandom) : VOL_W'($urandom_range(256));
  endfunction

  // corners: flat voices, volume extremes, axis cases, far cutoff, overflow volume
  task automatic test_directed();
    send_voice(9'd0, 24'sd0, 24'sd5, 24'sd5);
    send_voice(9'd256, 24'sd0, 24'sd0, 24'sd0);
    send_voice(9'h1FF, 24'sd0, 24'sd1, 24'sd1);        // flat path saturates
    send_voice(9'h1FF, 24'sd1, 24'sd0, 24'sd0);        // inside radius, saturates
    send_voice(9'd256, 24'sd1, 24'sd0, 24'sd0);        // one unit to the side
    send_voice(9'd256, 24'sd500, 24'sd0, 24'sd0);      // pure lateral, right near
    send_voice(9'd256, -24'sd500, 24'sd0, 24'sd0);     // pure lateral, left near
    send_voice(9'd256, 24'sd1, 24'sd0, 24'sd3000);     // straight ahead
    send_voice(9'd256, 24'sd300, 24'sd300, -24'sd300);
    send_voice(9'd200, 24'sd4000, 24'sd0, 24'sd4000);  // distance below 6000
    send_voice(9'd128, 24'sd20000, 24'sd0, 24'sd0);    // past cutoff
    send_voice(9'd256, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_voice(9'd256, 24'sh800000, 24'sh800000, 24'sh800000);
    send_voice(9'd256, 24'sd6128, 24'sd0, 24'sd0);     // d exactly 6000
    send_voice(9'd256, 24'sd10128, 24'sd0, 24'sd0);    // d exactly 10000
  endtask

  task automatic test_random(input int count);
    repeat (count) send_voice(rand_vol(), rand_pos(), rand_pos(), rand_pos());
  endtask

  // listener at corners of its range and in between, yaw registers past unity
  task automatic test_listener_settings();
    set_listener(0, 0, 0, 0, 16384, 0);
    test_random(250);
    set_listener(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, -16384, 0, 65535);
    test_random(250);
    set_listener(-24'sd3000, 24'sd77, 24'sd1200, 11585, -11585, 1);
    test_random(250);
    set_listener(24'sh800000, 24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 16'sh8000, 128);
    test_random(200);
    set_listener($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    test_random(200);
  endtask

  task automatic test_back_to_back();
    quiet_phase = 1'b1;
    test_random(300);
    quiet_phase = 1'b0;
  endtask

  initial begin
    int guard;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.base_volume = '0;
    in_ch.source_x = '0;
    in_ch.source_y = '0;
    in_ch.source_z = '0;
    mismatches = 0;
    gain_pairs_seen = 0;
    voices_sent = 0;
    cycles = 0;
    quiet_phase = 1'b0;
    cam_x = 0; cam_y = 0; cam_z = 0;
    yaw_c = 16384; yaw_s = 0; min_rad = 128;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values first, then corner listener settings
    test_directed();
    test_random(400);
    test_listener_settings();
    test_back_to_back();
    in_ch.valid <= 1'b0;

    guard = 0;
    while (expected_gains.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (expected_gains.size() != 0) begin
      mismatches++;
      $display("%0d expected gain pairs never arrived", expected_gains.size());
    end
    $display("covered %0d voices, %0d gain pairs checked, six listener settings",
             voices_sent, gain_pairs_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
